@@ rtl/core/gauss_seidel_grid_smoother_defines.svh @@
// Assertion macros used by the smoother's back end.
`ifndef GAUSS_SEIDEL_GRID_SMOOTHER_DEFINES_SVH
`define GAUSS_SEIDEL_GRID_SMOOTHER_DEFINES_SVH
`ifndef ASSERT_OFF
`define GSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define GSS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define GSS_ASSERT(lbl, prop, msg)
`define GSS_ASSERT_RST(lbl, prop, msg)
`endif
`endif

@@ rtl/core/gss_pkg.sv @@
// Types and constants shared by the smoother's modules.
package gss_pkg;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_SOLVE = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CFG_IMAGE_WIDTH    = 2'd0,
    CFG_IMAGE_HEIGHT   = 2'd1,
    CFG_STOP_THRESHOLD = 2'd2,
    CFG_SWEEP_LIMIT    = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_READ,
    BK_FETCH,
    BK_DIVIDE,
    BK_WRITE
  } bk_state_e;

  localparam int unsigned CfgDataBits = 40;
  localparam logic [39:0] SumMax      = 40'hFF_FFFF_FFFF;
  localparam logic [8:0]  RstWidth    = 9'd256;
  localparam logic [8:0]  RstHeight   = 9'd256;
  localparam logic [39:0] RstThresh   = 40'd1677722;
  localparam logic [15:0] RstLimit    = 16'd65535;

  typedef struct packed {
    logic [8:0]  image_width;
    logic [8:0]  image_height;
    logic [39:0] stop_threshold;
    logic [15:0] sweep_limit;
  } cfg_t;

  typedef struct packed {
    op_e         op;
    logic        in_store;
    logic [15:0] pixel_index;
    logic [15:0] pixel_value;
  } cmd_t;

  typedef struct packed {
    logic [15:0] read_value;
    logic [15:0] sweeps_done;
    logic        converged;
    logic [39:0] last_change_sum;
  } res_t;

endpackage

@@ rtl/core/gss_if.sv @@
// Word channel interfaces for the smoother's input and result streams.
interface gss_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [15:0] pixel_index;
  logic [15:0] pixel_value;
  modport source (output valid, opcode, pixel_index, pixel_value, input ready);
  modport sink (input valid, opcode, pixel_index, pixel_value, output ready);
endinterface

interface gss_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] read_value;
  logic [15:0] sweeps_done;
  logic        converged;
  logic [39:0] last_change_sum;
  modport source (output valid, read_value, sweeps_done, converged, last_change_sum,
                  input ready);
  modport sink (input valid, read_value, sweeps_done, converged, last_change_sum,
                output ready);
endinterface

@@ rtl/core/gauss_seidel_grid_smoother.sv @@
// Top level of the Gauss-Seidel five-point grid smoother.
//
//  channel  | dir | contents
//  in_ch    | in  | opcode, pixel_index, pixel_value
//  out_ch   | out | read_value, sweeps_done, converged, last_change_sum
//  cfg_*    | in  | write enable, register index, 40-bit data
//
// A load writes the store straight from the idle state; a read goes through the store's registered port.
// A solve visits each interior pixel once per sweep: six fetch steps for five store
// reads, one multiply by the reciprocal of five and one write, all on the one store.
// A two-word queue lets input be taken while the back end works or a result waits.
// Reset clears control state only; the store holds nothing defined until written.
module gauss_seidel_grid_smoother #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256,
  parameter int unsigned PIXEL_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  gss_in_if.sink                           in_ch,
  gss_out_if.source                        out_ch,
  input  logic                             cfg_we_i,
  input  logic [1:0]                       cfg_index_i,
  input  logic [gss_pkg::CfgDataBits-1:0]  cfg_data_i
);
  import gss_pkg::*;

  cfg_t cfg_q, cfg_d;
  cmd_t cmd;
  res_t res;
  logic cmd_valid, pop;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_IMAGE_WIDTH:    cfg_d.image_width    = cfg_data_i[8:0];
        CFG_IMAGE_HEIGHT:   cfg_d.image_height   = cfg_data_i[8:0];
        CFG_STOP_THRESHOLD: cfg_d.stop_threshold = cfg_data_i[39:0];
        CFG_SWEEP_LIMIT:    cfg_d.sweep_limit    = cfg_data_i[15:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width    <= RstWidth;
      cfg_q.image_height   <= RstHeight;
      cfg_q.stop_threshold <= RstThresh;
      cfg_q.sweep_limit    <= RstLimit;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  gss_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_ch.valid),
    .in_ready_o   (in_ch.ready),
    .opcode_i     (in_ch.opcode),
    .pixel_index_i(in_ch.pixel_index),
    .pixel_value_i(in_ch.pixel_value),
    .pop_i        (pop),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd)
  );

  gss_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .PIXEL_BITS(PIXEL_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd),
    .pop_o      (pop),
    .out_valid_o(out_ch.valid),
    .out_ready_i(out_ch.ready),
    .res_o      (res)
  );

  assign out_ch.read_value      = res.read_value;
  assign out_ch.sweeps_done     = res.sweeps_done;
  assign out_ch.converged       = res.converged;
  assign out_ch.last_change_sum = res.last_change_sum;
endmodule

@@ rtl/core/gss_ram.sv @@
// Generic simple dual-port RAM with registered read.
module gss_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

@@ rtl/core/gss_front.sv @@
// Front end: accepts words, classifies them and queues them for the back end.
module gss_front #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [1:0]    opcode_i,
  input  logic [15:0]   pixel_index_i,
  input  logic [15:0]   pixel_value_i,
  input  logic          pop_i,
  output logic          cmd_valid_o,
  output gss_pkg::cmd_t cmd_o
);
  import gss_pkg::*;

  localparam int unsigned StoreSize = MAX_WIDTH * MAX_HEIGHT;

  cmd_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push;
  cmd_t       cmd_new;

  assign in_ready_o  = (count_q != 2'd2);
  assign push        = in_valid_i && in_ready_o;
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = slot_q[rd_ptr_q];

  always_comb begin
    cmd_new.op          = op_e'(opcode_i);
    cmd_new.in_store    = (32'(pixel_index_i) < 32'(StoreSize));
    cmd_new.pixel_index = pixel_index_i;
    cmd_new.pixel_value = pixel_value_i;
  end

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= cmd_new;
    end
  end
endmodule

@@ rtl/core/gss_back.sv @@
// Back end: carries out loads, reads and relaxation sweeps over the image store.
`include "gauss_seidel_grid_smoother_defines.svh"
module gss_back #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256,
  parameter int unsigned PIXEL_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  gss_pkg::cfg_t cfg_i,
  input  logic          cmd_valid_i,
  input  gss_pkg::cmd_t cmd_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output gss_pkg::res_t res_o
);
  import gss_pkg::*;

  localparam int unsigned StoreSize = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW  = $clog2(StoreSize);
  localparam int unsigned DW  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned DH  = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned SW  = PIXEL_BITS + 3;
  localparam int unsigned RK  = PIXEL_BITS + 5;
  localparam logic [63:0]   RecipFull = ((64'd1 << RK) + 64'd4) / 64'd5;
  localparam logic [SW-1:0] RecipM    = RecipFull[SW-1:0];

  bk_state_e state_q, state_d;

  logic [DW-1:0]         w_q, w_d, col_q, col_d, w_clamp;
  logic [DH-1:0]         h_q, h_d, row_q, row_d, h_clamp;
  logic [AW-1:0]         at_q, at_d;
  logic [15:0]           lim_q, lim_d, sweeps_q, sweeps_d, sweeps_inc;
  logic [39:0]           acc_q, acc_d, acc_new;
  logic [40:0]           acc_sum;
  logic [2:0]            ph_q, ph_d;
  logic [SW-1:0]         sum_q, sum_d, div_q, div_d;
  logic [2*SW-1:0]       prod;
  logic [PIXEL_BITS-1:0] old_q, old_d, nv, diff;
  logic                  rd_ok_q, rd_ok_d;
  logic                  out_valid_q, out_valid_d;
  res_t                  res_q, res_d;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr, ram_raddr, nb_addr;
  logic [PIXEL_BITS-1:0] ram_wdata, ram_rdata;

  logic pop, last_col, last_row, sweep_end, stop_conv, stop_limit;

  gss_ram #(.WIDTH(PIXEL_BITS), .DEPTH(StoreSize)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign pop   = (state_q == BK_IDLE) && cmd_valid_i && (!out_valid_q || out_ready_i);
  assign pop_o = pop;

  always_comb begin
    if (cfg_i.image_width < 9'd3) begin
      w_clamp = DW'(3);
    end else if (32'(cfg_i.image_width) > 32'(MAX_WIDTH)) begin
      w_clamp = DW'(MAX_WIDTH);
    end else begin
      w_clamp = DW'(cfg_i.image_width);
    end
    if (cfg_i.image_height < 9'd3) begin
      h_clamp = DH'(3);
    end else if (32'(cfg_i.image_height) > 32'(MAX_HEIGHT)) begin
      h_clamp = DH'(MAX_HEIGHT);
    end else begin
      h_clamp = DH'(cfg_i.image_height);
    end
  end

  always_comb begin
    case (ph_q)
      3'd0:    nb_addr = at_q;
      3'd1:    nb_addr = at_q - AW'(w_q);
      3'd2:    nb_addr = at_q - AW'(1);
      3'd3:    nb_addr = at_q + AW'(w_q);
      default: nb_addr = at_q + AW'(1);
    endcase
  end

  assign prod       = (2*SW)'(div_q) * (2*SW)'(RecipM);
  assign nv         = div_q[PIXEL_BITS-1:0];
  assign diff       = (nv > old_q) ? (nv - old_q) : (old_q - nv);
  assign acc_sum    = {1'b0, acc_q} + 41'(diff);
  assign acc_new    = acc_sum[40] ? SumMax : acc_sum[39:0];
  assign last_col   = (col_q == w_q - DW'(2));
  assign last_row   = (row_q == h_q - DH'(2));
  assign sweep_end  = last_col && last_row;
  assign sweeps_inc = sweeps_q + 16'd1;
  assign stop_conv  = (acc_new < cfg_i.stop_threshold);
  assign stop_limit = (sweeps_inc >= lim_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (pop && cmd_i.op == OP_READ) begin
          state_d = BK_READ;
        end else if (pop && cmd_i.op == OP_SOLVE) begin
          state_d = BK_FETCH;
        end
      end
      BK_READ:   state_d = BK_IDLE;
      BK_FETCH:  state_d = (ph_q == 3'd5) ? BK_DIVIDE : BK_FETCH;
      BK_DIVIDE: state_d = BK_WRITE;
      BK_WRITE: begin
        if (sweep_end && (stop_conv || stop_limit)) begin
          state_d = BK_IDLE;
        end else begin
          state_d = BK_FETCH;
        end
      end
      default:   state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    w_d = w_q; h_d = h_q; col_d = col_q; row_d = row_q; at_d = at_q;
    lim_d = lim_q; sweeps_d = sweeps_q; acc_d = acc_q; ph_d = ph_q;
    sum_d = sum_q; div_d = div_q; old_d = old_q;
    rd_ok_d = rd_ok_q; res_d = res_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ram_we = 1'b0;
    ram_waddr = cmd_i.pixel_index[AW-1:0];
    ram_wdata = PIXEL_BITS'(cmd_i.pixel_value);
    ram_raddr = cmd_i.pixel_index[AW-1:0];
    case (state_q)
      BK_IDLE: begin
        if (pop) begin
          res_d = '0;
          rd_ok_d = cmd_i.in_store;
          case (cmd_i.op)
            OP_LOAD: begin
              ram_we = cmd_i.in_store;
              out_valid_d = 1'b1;
            end
            OP_SOLVE: begin
              w_d = w_clamp;
              h_d = h_clamp;
              col_d = DW'(1);
              row_d = DH'(1);
              at_d = AW'(w_clamp) + AW'(1);
              lim_d = (cfg_i.sweep_limit == 16'd0) ? 16'd1 : cfg_i.sweep_limit;
              sweeps_d = 16'd0;
              acc_d = '0;
              ph_d = 3'd0;
              sum_d = '0;
            end
            OP_READ: begin
            end
            default: out_valid_d = 1'b1;
          endcase
        end
      end
      BK_READ: begin
        res_d.read_value = rd_ok_q ? 16'(ram_rdata) : 16'd0;
        out_valid_d = 1'b1;
      end
      BK_FETCH: begin
        ram_raddr = nb_addr;
        ph_d = ph_q + 3'd1;
        if (ph_q != 3'd0) begin
          sum_d = sum_q + SW'(ram_rdata);
        end
        if (ph_q == 3'd1) begin
          old_d = ram_rdata;
        end
        if (ph_q == 3'd5) begin
          div_d = sum_q + SW'(ram_rdata) + SW'(2);
        end
      end
      BK_DIVIDE: begin
        div_d = SW'(prod[RK +: PIXEL_BITS]);
      end
      BK_WRITE: begin
        ram_we = 1'b1;
        ram_waddr = at_q;
        ram_wdata = nv;
        acc_d = acc_new;
        ph_d = 3'd0;
        sum_d = '0;
        if (!last_col) begin
          col_d = col_q + DW'(1);
          at_d = at_q + AW'(1);
        end else if (!last_row) begin
          col_d = DW'(1);
          row_d = row_q + DH'(1);
          at_d = at_q + AW'(3);
        end else begin
          sweeps_d = sweeps_inc;
          col_d = DW'(1);
          row_d = DH'(1);
          at_d = AW'(w_q) + AW'(1);
          if (stop_conv || stop_limit) begin
            out_valid_d = 1'b1;
            res_d.read_value = 16'd0;
            res_d.sweeps_done = sweeps_inc;
            res_d.converged = stop_conv;
            res_d.last_change_sum = acc_new;
          end else begin
            acc_d = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
      acc_q       <= '0;
      sweeps_q    <= '0;
      ph_q        <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      acc_q       <= acc_d;
      sweeps_q    <= sweeps_d;
      ph_q        <= ph_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q <= w_d; h_q <= h_d; col_q <= col_d; row_q <= row_d; at_q <= at_d;
    lim_q <= lim_d; sum_q <= sum_d; div_q <= div_d;
    old_q <= old_d; rd_ok_q <= rd_ok_d; res_q <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  `GSS_ASSERT(a_pop_idle, pop |-> state_q == BK_IDLE, "word taken while busy")
  `GSS_ASSERT(a_slot_free, (state_q == BK_FETCH || state_q == BK_DIVIDE) |-> !out_valid_q,
              "result slot occupied during a solve")
  `GSS_ASSERT(a_solve_write, (ram_we && state_q != BK_IDLE) |-> state_q == BK_WRITE,
              "store written outside the write step")
  `GSS_ASSERT_RST(a_rst_idle, $rose(rst_ni) |-> (state_q == BK_IDLE && !out_valid_q),
                  "back end not idle after reset")
endmodule
